[rtl/fmbs_pkg.sv]
// ----------------------------------------------------------------------------
// fmbs_pkg
// Shared widths, limits and codes of the FM-index backward search core.
// ----------------------------------------------------------------------------
package fmbs_pkg;

	localparam int MAX_TEXT     = 65536;
	localparam int MAX_BLOCKS   = 1024;
	localparam int ALPHABET     = 256;

	localparam int CNT_W        = 17;
	localparam int SYM_W        = 8;
	localparam int IDX_W        = 18;
	localparam int BLK_W        = 10;
	localparam int TEXT_AW      = 16;
	localparam int CKPT_AW      = BLK_W + SYM_W;
	localparam int BCNT_W       = 11;

	localparam int IN_DATA_W    = 48;
	localparam int IN_USER_W    = 3;
	localparam int OUT_DATA_W   = 56;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CNT_W-1:0] END_MAX = 17'h1FFFF;

	typedef enum logic [1:0] {
		ACT_LOAD_START = 2'd0,
		ACT_LOAD_CKPT  = 2'd1,
		ACT_LOAD_TEXT  = 2'd2,
		ACT_SEARCH     = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEXT_LENGTH = 2'd0,
		REG_CKPT_STEP   = 2'd1,
		REG_BLOCK_COUNT = 2'd2
	} cfg_reg_t;

endpackage

[rtl/fmbs_ram.sv]
// ----------------------------------------------------------------------------
// fmbs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module fmbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/fm_index_backward_search_core.sv]
// ----------------------------------------------------------------------------
// fm_index_backward_search_core
// FM-index backward search over tables held in on-chip RAM.
// ----------------------------------------------------------------------------
// Input beats on s_axis: tuser carries the action and the first flag, tlast
// marks the final pattern symbol. Load actions write the start count, the
// checkpoint or the text RAM. A search symbol narrows the interval
// [low, high): for each end the rank position is divided by the checkpoint
// step (restoring divider), the block start is formed by one multiply, and
// the text RAM is scanned one byte a cycle from the block start to the
// position. The scan is shorter than the checkpoint step, except where the
// position lies past the last block in use, when it can reach the text
// length. An empty interval skips the rank work.
// The final symbol of a pattern yields one beat on m_axis with the interval
// and its size. A result is held in the output register until taken; the
// core accepts loads meanwhile and waits only when the next result is due.
// Reset clears the interval, the control state and the registers to their
// defaults; the RAM contents are undefined until loaded.
// ----------------------------------------------------------------------------
module fm_index_backward_search_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [fmbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fmbs_pkg::CNT_W-1:0]          cfg_data,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// index[17:0], value[34:18], symbol[42:35], zero fill
	input  logic [fmbs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// action[1:0], first[2]
	input  logic [fmbs_pkg::IN_USER_W-1:0]      s_axis_tuser,
	input  logic                                s_axis_tlast,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// interval_low[16:0], interval_high[33:17], match_count[50:34], zero fill
	output logic [fmbs_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	localparam int CW = fmbs_pkg::CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_BASE, ST_POS, ST_DIV, ST_MUL, ST_SCAN, ST_ACC, ST_FINISH
	} state_t;

	state_t state_q;

	// configuration
	logic [CW-1:0]                  text_length_q, ckpt_step_q;
	logic [fmbs_pkg::BCNT_W-1:0]    block_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_length_q <= CW'(1);
			ckpt_step_q   <= CW'(64);
			block_count_q <= fmbs_pkg::BCNT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				fmbs_pkg::REG_TEXT_LENGTH: text_length_q <= cfg_data;
				fmbs_pkg::REG_CKPT_STEP:   ckpt_step_q   <= cfg_data;
				fmbs_pkg::REG_BLOCK_COUNT: block_count_q <= cfg_data[fmbs_pkg::BCNT_W-1:0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0]               eff_len, eff_step;
	logic [fmbs_pkg::BCNT_W-1:0] eff_blocks;

	always_comb begin
		eff_len  = (text_length_q > CW'(fmbs_pkg::MAX_TEXT)) ?
			CW'(fmbs_pkg::MAX_TEXT) : text_length_q;
		eff_step = (ckpt_step_q == '0) ? CW'(1) : ckpt_step_q;
		if (block_count_q == '0) begin
			eff_blocks = fmbs_pkg::BCNT_W'(1);
		end else if (block_count_q > fmbs_pkg::BCNT_W'(fmbs_pkg::MAX_BLOCKS)) begin
			eff_blocks = fmbs_pkg::BCNT_W'(fmbs_pkg::MAX_BLOCKS);
		end else begin
			eff_blocks = block_count_q;
		end
	end

	// input fields
	logic [fmbs_pkg::IDX_W-1:0] in_index;
	logic [CW-1:0]              in_value;
	logic [fmbs_pkg::SYM_W-1:0] in_symbol;
	fmbs_pkg::action_t          in_action;
	logic                       in_first, in_acc;

	assign in_index  = s_axis_tdata[17:0];
	assign in_value  = s_axis_tdata[34:18];
	assign in_symbol = s_axis_tdata[42:35];
	assign in_action = fmbs_pkg::action_t'(s_axis_tuser[1:0]);
	assign in_first  = s_axis_tuser[2];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// search state
	logic [CW-1:0]              lo_q, hi_q, nlo_q, pos_q, rem_q, div_q, idx_q, cnt_q, base_q;
	logic [fmbs_pkg::SYM_W-1:0] sym_q;
	logic [4:0]                 div_cnt_q;
	logic                       dead_q, last_q, sel_q, rz_q, pend_s1;

	// RAMs
	logic [CW-1:0]                    sc_rdata, ck_rdata;
	logic [fmbs_pkg::SYM_W-1:0]       tx_rdata;
	logic                             ck_re, tx_re;
	logic [fmbs_pkg::CKPT_AW-1:0]     ck_raddr;
	logic [fmbs_pkg::BLK_W-1:0]       blk;
	logic [fmbs_pkg::BLK_W+CW-1:0]    prod;

	fmbs_ram #(.WIDTH(CW), .DEPTH(fmbs_pkg::ALPHABET)) u_start_ram (
		.clk   (clk),
		.we    (in_acc && in_action == fmbs_pkg::ACT_LOAD_START && in_index[17:8] == '0),
		.waddr (in_index[7:0]),
		.wdata (in_value),
		.re    (in_acc && in_action == fmbs_pkg::ACT_SEARCH),
		.raddr (in_symbol),
		.rdata (sc_rdata)
	);

	fmbs_ram #(.WIDTH(CW), .DEPTH(fmbs_pkg::MAX_BLOCKS * fmbs_pkg::ALPHABET)) u_ckpt_ram (
		.clk   (clk),
		.we    (in_acc && in_action == fmbs_pkg::ACT_LOAD_CKPT),
		.waddr (in_index),
		.wdata (in_value),
		.re    (ck_re),
		.raddr (ck_raddr),
		.rdata (ck_rdata)
	);

	fmbs_ram #(.WIDTH(fmbs_pkg::SYM_W), .DEPTH(fmbs_pkg::MAX_TEXT)) u_text_ram (
		.clk   (clk),
		.we    (in_acc && in_action == fmbs_pkg::ACT_LOAD_TEXT && in_index[17:16] == '0),
		.waddr (in_index[fmbs_pkg::TEXT_AW-1:0]),
		.wdata (in_value[7:0]),
		.re    (tx_re),
		.raddr (idx_q[fmbs_pkg::TEXT_AW-1:0]),
		.rdata (tx_rdata)
	);

	// block number clamped to the last block in use
	always_comb begin
		if (div_q >= CW'(eff_blocks)) begin
			blk = fmbs_pkg::BLK_W'(eff_blocks - fmbs_pkg::BCNT_W'(1));
		end else begin
			blk = div_q[fmbs_pkg::BLK_W-1:0];
		end
		prod = blk * eff_step;
	end

	assign ck_re    = (state_q == ST_MUL);
	assign ck_raddr = {blk, sym_q};
	assign tx_re    = (state_q == ST_SCAN) && (idx_q < pos_q);

	// divider step
	logic [CW:0]   trial;
	logic          ge;
	logic [CW-1:0] pos_sel, pos_clamp;

	assign trial     = {rem_q, div_q[CW-1]};
	assign ge        = trial >= {1'b0, eff_step};
	assign pos_sel   = sel_q ? hi_q : lo_q;
	assign pos_clamp = (pos_sel > eff_len) ? eff_len : pos_sel;

	// interval end
	logic [CW+1:0] sum;
	logic [CW-1:0] sum_sat;

	assign sum     = (CW+2)'(base_q) + (CW+2)'(rz_q ? '0 : ck_rdata) + (CW+2)'(cnt_q);
	assign sum_sat = (sum > (CW+2)'(fmbs_pkg::END_MAX)) ? fmbs_pkg::END_MAX : sum[CW-1:0];

	logic [CW-1:0] out_lo_q, out_hi_q;
	logic          out_load;

	// load the output register when the final symbol is done and the slot is free
	assign out_load = (state_q == ST_FINISH) && last_q && (!m_axis_tvalid || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			lo_q          <= '0;
			hi_q          <= '0;
			dead_q        <= 1'b0;
			m_axis_tvalid <= 1'b0;
			pend_s1       <= 1'b0;
		end else begin
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_action == fmbs_pkg::ACT_SEARCH) begin
						sym_q  <= in_symbol;
						last_q <= s_axis_tlast;
						sel_q  <= 1'b0;
						if (in_first) begin
							lo_q   <= '0;
							hi_q   <= eff_len;
							dead_q <= 1'b0;
						end
						state_q <= (dead_q && !in_first) ? ST_FINISH : ST_BASE;
					end
				end
				ST_BASE: begin
					base_q  <= sc_rdata;
					state_q <= ST_POS;
				end
				ST_POS: begin
					cnt_q     <= '0;
					rem_q     <= '0;
					div_q     <= pos_clamp;
					pos_q     <= pos_clamp;
					div_cnt_q <= '0;
					rz_q      <= (pos_sel == '0);
					state_q   <= (pos_sel == '0) ? ST_ACC : ST_DIV;
				end
				ST_DIV: begin
					rem_q     <= ge ? CW'(trial - {1'b0, eff_step}) : trial[CW-1:0];
					div_q     <= {div_q[CW-2:0], ge};
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(CW - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// checkpoint read issued here; scan from the block start
					idx_q   <= prod[CW-1:0];
					pend_s1 <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					pend_s1 <= tx_re;
					if (tx_re) begin
						idx_q <= idx_q + CW'(1);
					end
					if (pend_s1 && tx_rdata == sym_q) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (!tx_re && !pend_s1) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (!sel_q) begin
						nlo_q   <= sum_sat;
						sel_q   <= 1'b1;
						state_q <= ST_POS;
					end else begin
						if (nlo_q >= sum_sat) begin
							lo_q   <= '0;
							hi_q   <= '0;
							dead_q <= 1'b1;
						end else begin
							lo_q <= nlo_q;
							hi_q <= sum_sat;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_load) begin
						out_lo_q <= lo_q;
						out_hi_q <= hi_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tdata = {5'd0, CW'(out_hi_q - out_lo_q), out_hi_q, out_lo_q};

	// checks
	a_out_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_lo_q <= out_hi_q)
		else $error("result interval inverted");

	a_dead_empty: assert property (@(posedge clk) disable iff (!arst_n)
		dead_q |-> (lo_q == '0 && hi_q == '0))
		else $error("dead interval not empty");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> idx_q <= pos_q)
		else $error("scan ran past rank position");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(out_lo_q) && $stable(out_hi_q))
		else $error("pending result overwritten");

endmodule

[verif/tb_fm_index_backward_search_core.sv]
// ----------------------------------------------------------------------------
// tb_fm_index_backward_search_core
// Self-checking bench for the FM-index backward search core: loads index
// tables built from random texts and runs pattern searches under several
// register settings. Each result beat is checked against a local interval model.
// ----------------------------------------------------------------------------
module tb_fm_index_backward_search_core;

	localparam int LIMIT = 500000;

	typedef struct {
		logic [fmbs_pkg::CNT_W-1:0] lo;
		logic [fmbs_pkg::CNT_W-1:0] hi;
		logic [fmbs_pkg::CNT_W-1:0] cnt;
	} interval_t;

	typedef struct {
		fmbs_pkg::action_t act;
		int      idx;
		int      val;
		int      sym;
		bit      fst;
		bit      lst;
		bit      typed;
		int      lo;
		int      hi;
	} dir_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [fmbs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [fmbs_pkg::CNT_W-1:0]      cfg_data;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [fmbs_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic [fmbs_pkg::IN_USER_W-1:0]  s_axis_tuser;
	logic                            s_axis_tlast;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [fmbs_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	fm_index_backward_search_core dut (.*);

	// interval model state
	logic [fmbs_pkg::CNT_W-1:0] start_tab [fmbs_pkg::ALPHABET];
	logic [fmbs_pkg::CNT_W-1:0] ckpt_tab [fmbs_pkg::MAX_BLOCKS*fmbs_pkg::ALPHABET];
	logic [7:0]                 text_tab [fmbs_pkg::MAX_TEXT];
	int                         iv_low, iv_high;
	bit                         iv_dead;
	int                         reg_len, reg_step, reg_blocks;

	interval_t pending_intervals [$];
	int        errors, cycles, items_sent, results_seen, searches_sent;
	bit        quiet;
	int        hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int eff_len();
		return reg_len > fmbs_pkg::MAX_TEXT ? fmbs_pkg::MAX_TEXT : reg_len;
	endfunction

	function automatic int eff_step();
		return reg_step == 0 ? 1 : reg_step;
	endfunction

	function automatic int eff_blocks();
		if (reg_blocks == 0) return 1;
		return reg_blocks > fmbs_pkg::MAX_BLOCKS ? fmbs_pkg::MAX_BLOCKS : reg_blocks;
	endfunction

	function automatic int sat_end(longint v);
		return v > 131071 ? 131071 : int'(v);
	endfunction

	function automatic longint rank_at(int sym, int pos);
		int     p, blk, i;
		longint n;
		p = pos;
		n = 0;
		if (p == 0) return 0;
		if (p > eff_len()) p = eff_len();
		blk = p / eff_step();
		if (blk >= eff_blocks()) blk = eff_blocks() - 1;
		for (i = blk * eff_step(); i < p; i++)
			if (text_tab[i] == sym[7:0]) n++;
		return longint'(ckpt_tab[blk*fmbs_pkg::ALPHABET + sym]) + n;
	endfunction

	// update the model for one accepted beat; returns 1 when a result is due
	function automatic bit model_beat(fmbs_pkg::action_t act, int idx, int val, int sym,
			bit fst, bit lst, output interval_t r);
		longint base;
		r = '{default: '0};
		case (act)
			fmbs_pkg::ACT_LOAD_START:
				if (idx < fmbs_pkg::ALPHABET) start_tab[idx] = val[fmbs_pkg::CNT_W-1:0];
			fmbs_pkg::ACT_LOAD_CKPT:
				if (idx < fmbs_pkg::MAX_BLOCKS*fmbs_pkg::ALPHABET)
					ckpt_tab[idx] = val[fmbs_pkg::CNT_W-1:0];
			fmbs_pkg::ACT_LOAD_TEXT:
				if (idx < fmbs_pkg::MAX_TEXT) text_tab[idx] = val[7:0];
			default: begin
				if (fst) begin
					iv_low = 0;
					iv_high = sat_end(eff_len());
					iv_dead = 0;
				end
				if (!iv_dead) begin
					base = start_tab[sym];
					iv_low = sat_end(base + rank_at(sym, iv_low));
					iv_high = sat_end(base + rank_at(sym, iv_high));
					if (iv_low >= iv_high) begin
						iv_low = 0;
						iv_high = 0;
						iv_dead = 1;
					end
				end
				r.lo = iv_low[fmbs_pkg::CNT_W-1:0];
				r.hi = iv_high[fmbs_pkg::CNT_W-1:0];
				r.cnt = r.hi - r.lo;
				return lst;
			end
		endcase
		return 0;
	endfunction

	task automatic write_reg(fmbs_pkg::cfg_reg_t r, int v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v[fmbs_pkg::CNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			fmbs_pkg::REG_TEXT_LENGTH: reg_len = v & 17'h1FFFF;
			fmbs_pkg::REG_CKPT_STEP:   reg_step = v & 17'h1FFFF;
			default:                   reg_blocks = v & 11'h7FF;
		endcase
	endtask

	// offer one beat and hold it until taken; tvalid stays high on return
	task automatic send_beat(fmbs_pkg::action_t act, int idx, int val, int sym, bit fst,
			bit lst, bit typed = 0, int lo = 0, int hi = 0);
		interval_t r;
		if (!quiet && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, sym[7:0], val[fmbs_pkg::CNT_W-1:0], idx[fmbs_pkg::IDX_W-1:0]};
		s_axis_tuser <= {fst, act};
		s_axis_tlast <= lst;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (act == fmbs_pkg::ACT_SEARCH) searches_sent++;
		if (model_beat(act, idx, val, sym, fst, lst, r)) begin
			if (typed) begin
				r.lo = lo[fmbs_pkg::CNT_W-1:0];
				r.hi = hi[fmbs_pkg::CNT_W-1:0];
				r.cnt = r.hi - r.lo;
			end
			pending_intervals = {pending_intervals, r};
		end
	endtask

	// wait for all results, then for any symbol still in progress
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_intervals.size() == 0);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ignored load: index beyond its table
	task automatic send_noise();
		if ($urandom_range(1))
			send_beat(fmbs_pkg::ACT_LOAD_START, $urandom_range(fmbs_pkg::ALPHABET, 262143),
				$urandom_range(131071), $urandom_range(255), $urandom_range(1),
				$urandom_range(1));
		else
			send_beat(fmbs_pkg::ACT_LOAD_TEXT, $urandom_range(fmbs_pkg::MAX_TEXT, 262143),
				$urandom_range(131071), $urandom_range(255), $urandom_range(1),
				$urandom_range(1));
	endtask

	// load a random text over a small alphabet with true tables, then search it
	task automatic run_phase(int len, int stp, int blks, int npat, bit hold);
		int syms [5];
		int occ [fmbs_pkg::ALPHABET];
		int n, i, b, k, pos, maxb, plen, p, s;
		bit fst;
		write_reg(fmbs_pkg::REG_TEXT_LENGTH, len);
		write_reg(fmbs_pkg::REG_CKPT_STEP, stp);
		write_reg(fmbs_pkg::REG_BLOCK_COUNT, blks);
		n = eff_len();
		syms[0] = 0;
		syms[1] = 255;
		for (i = 2; i < 5; i++) syms[i] = $urandom_range(1, 254);
		for (i = 0; i < n; i++) begin
			send_beat(fmbs_pkg::ACT_LOAD_TEXT, i,
				{$urandom_range(511), 8'd0} | syms[$urandom_range(4)],
				$urandom_range(255), $urandom_range(1), $urandom_range(1));
			if ($urandom_range(99) < 3) send_noise();
		end
		for (k = 0; k < 5; k++) begin
			s = 0;
			for (i = 0; i < n; i++) if (text_tab[i] < syms[k]) s++;
			send_beat(fmbs_pkg::ACT_LOAD_START, syms[k], s, $urandom_range(255), 0,
				$urandom_range(1));
		end
		for (i = 0; i < fmbs_pkg::ALPHABET; i++) occ[i] = 0;
		pos = 0;
		maxb = n / eff_step();
		if (maxb > eff_blocks() - 1) maxb = eff_blocks() - 1;
		for (b = 0; b <= maxb; b++) begin
			while (pos < n && pos < b * eff_step()) begin
				occ[text_tab[pos]]++;
				pos++;
			end
			for (k = 0; k < 5; k++)
				send_beat(fmbs_pkg::ACT_LOAD_CKPT, b*fmbs_pkg::ALPHABET + syms[k],
					occ[syms[k]], $urandom_range(255), $urandom_range(1), 0);
		end
		if (hold) hold_left = 400;
		for (k = 0; k < npat; k++) begin
			plen = $urandom_range(1, n > 1000 ? 2 : 4);
			fst = $urandom_range(99) >= 15;
			p = (n >= plen) ? $urandom_range(n - plen) : 0;
			for (i = plen - 1; i >= 0; i--) begin
				if (n >= plen && $urandom_range(99) < 85) s = text_tab[p + i];
				else s = syms[$urandom_range(4)];
				send_beat(fmbs_pkg::ACT_SEARCH, $urandom_range(262143), $urandom_range(131071),
					s, fst && (i == plen - 1), i == 0);
				if ($urandom_range(99) < 8) send_noise();
			end
		end
		drain();
	endtask

	// text length above the table: the high end falls in the second block at its
	// start, so single symbol patterns read start counts and checkpoints only
	task automatic run_clamped(int npat);
		int syms [5];
		int k;
		write_reg(fmbs_pkg::REG_TEXT_LENGTH, 131071);
		write_reg(fmbs_pkg::REG_CKPT_STEP, 65536);
		write_reg(fmbs_pkg::REG_BLOCK_COUNT, 2);
		for (k = 0; k < 5; k++) begin
			syms[k] = $urandom_range(255);
			send_beat(fmbs_pkg::ACT_LOAD_START, syms[k], $urandom_range(65536),
				$urandom_range(255), 0, 0);
			send_beat(fmbs_pkg::ACT_LOAD_CKPT, fmbs_pkg::ALPHABET + syms[k],
				$urandom_range(65536), $urandom_range(255), 0, 0);
		end
		for (k = 0; k < npat; k++)
			send_beat(fmbs_pkg::ACT_SEARCH, $urandom_range(262143), $urandom_range(131071),
				syms[$urandom_range(4)], 1, 1);
		drain();
	endtask

	// result side: check each taken beat, then choose the next tready
	always @(posedge clk) begin
		interval_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_intervals.size() == 0) begin
				$error("result beat with no expectation: %h", m_axis_tdata);
				errors++;
			end else begin
				e = pending_intervals.pop_front();
				if (m_axis_tdata[16:0] !== e.lo) begin
					$error("interval_low exp %0d got %0d", e.lo, m_axis_tdata[16:0]);
					errors++;
				end
				if (m_axis_tdata[33:17] !== e.hi) begin
					$error("interval_high exp %0d got %0d", e.hi, m_axis_tdata[33:17]);
					errors++;
				end
				if (m_axis_tdata[50:34] !== e.cnt) begin
					$error("match_count exp %0d got %0d", e.cnt, m_axis_tdata[50:34]);
					errors++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= quiet || ($urandom_range(99) >= 29);
		end
	end

	initial begin
		dir_row_t rows [13];
		rows = '{
			'{fmbs_pkg::ACT_LOAD_START, 0, 3, 0, 0, 1, 0, 0, 0},
			// search before any first symbol: stays empty
			'{fmbs_pkg::ACT_SEARCH, 0, 0, 0, 0, 1, 1, 0, 0},
			'{fmbs_pkg::ACT_LOAD_TEXT, 0, 511, 255, 1, 0, 0, 0, 0},
			'{fmbs_pkg::ACT_LOAD_START, 255, 65536, 0, 0, 0, 0, 0, 0},
			'{fmbs_pkg::ACT_LOAD_CKPT, 255, 131071, 0, 0, 0, 0, 0, 0},
			'{fmbs_pkg::ACT_LOAD_CKPT, 0, 0, 0, 0, 0, 0, 0, 0},
			// high end saturates
			'{fmbs_pkg::ACT_SEARCH, 262143, 131071, 255, 1, 1, 1, 65536, 131071},
			'{fmbs_pkg::ACT_LOAD_START, 256, 7, 0, 0, 1, 0, 0, 0},
			'{fmbs_pkg::ACT_LOAD_CKPT, 262143, 7, 0, 0, 0, 0, 0, 0},
			'{fmbs_pkg::ACT_LOAD_TEXT, 65536, 7, 0, 1, 1, 0, 0, 0},
			'{fmbs_pkg::ACT_SEARCH, 0, 0, 0, 1, 1, 1, 0, 0},
			// dead interval holds
			'{fmbs_pkg::ACT_SEARCH, 0, 0, 255, 0, 1, 1, 0, 0},
			'{fmbs_pkg::ACT_SEARCH, 0, 0, 255, 1, 0, 0, 0, 0}
		};
		errors = 0;
		cycles = 0;
		items_sent = 0;
		results_seen = 0;
		searches_sent = 0;
		quiet = 0;
		hold_left = 0;
		iv_low = 0;
		iv_high = 0;
		iv_dead = 0;
		reg_len = 1;
		reg_step = 64;
		reg_blocks = 1;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= fmbs_pkg::REG_TEXT_LENGTH;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		s_axis_tlast <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_beat(rows[i].act, rows[i].idx, rows[i].val, rows[i].sym, rows[i].fst,
				rows[i].lst, rows[i].typed, rows[i].lo, rows[i].hi);
		send_beat(fmbs_pkg::ACT_SEARCH, 0, 0, 255, 0, 1);
		drain();

		run_phase(0, 0, 0, 2, 0);
		run_phase(1, 1, 1, 3, 0);
		run_phase(29, 8, 3, 10, 1);
		quiet = 1;
		run_phase(16, 7, 9, 8, 0);
		quiet = 0;
		run_phase(6, 0, 2047, 6, 0);
		run_phase(20, 65536, 4, 6, 1);
		run_phase(30, 13, 5, 6, 0);
		run_clamped(10);
		run_phase(12, 3, 1024, 6, 0);

		repeat (50) @(posedge clk);
		$display("Covered %0d beats (%0d search symbols) over nine register settings,",
			items_sent, searches_sent);
		$display("%0d result beats checked, %0d mismatches.", results_seen, errors);
		if (errors == 0 && pending_intervals.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
